// ===== design/rrqd_pkg.sv =====
// Shared types and constants for the round-robin quantum dispatcher.
`default_nettype none

package rrqd_pkg;

    localparam logic MODE_ADD      = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    localparam logic [15:0] QUANTUM_RESET = 16'd10;

    typedef struct packed {
        logic        mode;
        logic [7:0]  task_id;
        logic [15:0] burst;
    } item_t;

    typedef struct packed {
        logic [7:0]  served_id;
        logic [15:0] slice;
        logic        finished;
        logic        empty_res;
        logic        rejected;
    } res_t;

    typedef struct packed {
        logic [7:0]  ident;
        logic [15:0] remaining;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic miss;
    } scan_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_READ,
        ST_CALC,
        ST_NEXT
    } state_t;

endpackage

`default_nettype wire

// ===== design/rrqd_table.sv =====
// Task table memory: id and remaining burst per slot, one write and one registered read.
`default_nettype none

module rrqd_table #(
    parameter int MAX_TASKS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [$clog2(MAX_TASKS)-1:0] waddr,
    input  wire rrqd_pkg::entry_t             wdata,
    input  wire logic                         re,
    input  wire logic [$clog2(MAX_TASKS)-1:0] raddr,
    output rrqd_pkg::entry_t                  rdata
);

    rrqd_pkg::entry_t mem [MAX_TASKS];
    rrqd_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/rrqd_scan.sv =====
// Live-slot scanner: walks slots downward with wrap, one slot per cycle, stopping at a live slot or after one full lap.
`default_nettype none

module rrqd_scan #(
    parameter int MAX_TASKS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         launch,
    input  wire logic [$clog2(MAX_TASKS)-1:0] from,
    input  wire logic [MAX_TASKS-1:0]         live,
    output rrqd_pkg::scan_stat_t              stat,
    output logic [$clog2(MAX_TASKS)-1:0]      idx
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int FW = $clog2(MAX_TASKS + 1);

    logic          run_reg, run_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [FW-1:0] cnt_reg, cnt_next;

    assign stat.hit  = run_reg & live[idx_reg];
    assign stat.miss = run_reg & ~live[idx_reg] & (cnt_reg == FW'(1));
    assign idx       = idx_reg;

    always_comb
    begin
        run_next = run_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        if (launch)
        begin
            run_next = 1'b1;
            idx_next = from;
            cnt_next = FW'(MAX_TASKS);
        end
        else if (run_reg)
        begin
            if (stat.hit || stat.miss)
            begin
                run_next = 1'b0;
            end
            else
            begin
                // step to the next older slot, wrap to the top
                idx_next = (idx_reg == '0) ? IW'(MAX_TASKS - 1) : idx_reg - IW'(1);
                cnt_next = cnt_reg - FW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/round_robin_quantum_dispatcher_unit.sv =====
// Top level of the round-robin quantum dispatcher: sequencer, live bits and slice unit.
//
// Usage: an item is taken on a rising edge with start high and busy low. item.mode
// selects add (store task_id and burst in the next free slot) or dispatch (serve the
// task at the cursor for min(quantum, remaining)). Every item yields one result beat,
// shown on result for exactly one cycle while done is high; the receiver cannot stall.
// An add gives its result in the next cycle and busy stays low, so adds may come every
// cycle. A dispatch holds busy high: the slot is read (ST_READ) and the slice formed
// (ST_CALC), then the live-slot scanner checks one slot per cycle for the next older
// live task, wrapping to the newest. A stale cursor adds a first scan for the newest
// live task. An empty dispatch scans one full lap and returns an empty result.
// The quantum register is written through cfg_valid/cfg_ready/cfg_data (cfg_ready is
// always high) and must only be written while the block is idle.
// Reset clears all live bits, the fill pointer and the cursor and sets quantum to 10.
// The table memory needs no clearing: only live slots are ever read.
`default_nettype none

module round_robin_quantum_dispatcher_unit #(
    parameter int MAX_TASKS = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire rrqd_pkg::item_t item,
    output logic                 done,
    output rrqd_pkg::res_t       result,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [15:0]     cfg_data
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int FW = $clog2(MAX_TASKS + 1);

    rrqd_pkg::state_t      state_reg, state_next;
    logic [15:0]           quantum_reg, quantum_next;
    logic [MAX_TASKS-1:0]  live_reg, live_next;
    logic [FW-1:0]         fill_reg, fill_next;
    logic [IW-1:0]         cursor_reg, cursor_next;
    logic [IW-1:0]         slot_reg, slot_next;
    logic                  done_reg, done_next;
    rrqd_pkg::res_t        result_reg, result_next;

    logic                  accept;
    logic                  mem_we, mem_re;
    logic [IW-1:0]         mem_waddr;
    rrqd_pkg::entry_t      mem_wdata, mem_rdata;
    logic                  scan_launch;
    logic [IW-1:0]         scan_from, scan_idx;
    rrqd_pkg::scan_stat_t  scan_stat;

    logic [15:0]           slice_val, rem_left;
    logic                  table_full;

    rrqd_table #(.MAX_TASKS(MAX_TASKS)) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (slot_reg),
        .rdata (mem_rdata)
    );

    rrqd_scan #(.MAX_TASKS(MAX_TASKS)) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (scan_launch),
        .from   (scan_from),
        .live   (live_reg),
        .stat   (scan_stat),
        .idx    (scan_idx)
    );

    assign accept     = start && (state_reg == rrqd_pkg::ST_IDLE);
    assign table_full = (fill_reg == FW'(MAX_TASKS));

    // slice unit: one compare, one subtract
    assign slice_val = (quantum_reg < mem_rdata.remaining) ? quantum_reg
                                                           : mem_rdata.remaining;
    assign rem_left  = mem_rdata.remaining - slice_val;

    assign busy      = (state_reg != rrqd_pkg::ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rrqd_pkg::ST_IDLE:
            begin
                if (accept && item.mode == rrqd_pkg::MODE_DISPATCH)
                begin
                    state_next = live_reg[cursor_reg] ? rrqd_pkg::ST_READ
                                                      : rrqd_pkg::ST_FIND;
                end
            end
            rrqd_pkg::ST_FIND:
            begin
                if (scan_stat.hit)
                begin
                    state_next = rrqd_pkg::ST_READ;
                end
                else if (scan_stat.miss)
                begin
                    state_next = rrqd_pkg::ST_IDLE;
                end
            end
            rrqd_pkg::ST_READ:
            begin
                state_next = rrqd_pkg::ST_CALC;
            end
            rrqd_pkg::ST_CALC:
            begin
                state_next = rrqd_pkg::ST_NEXT;
            end
            rrqd_pkg::ST_NEXT:
            begin
                if (scan_stat.hit || scan_stat.miss)
                begin
                    state_next = rrqd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrqd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        quantum_next = cfg_valid ? cfg_data : quantum_reg;
        live_next    = live_reg;
        fill_next    = fill_reg;
        cursor_next  = cursor_reg;
        slot_next    = slot_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = slot_reg;
        mem_wdata    = '0;
        scan_launch  = 1'b0;
        scan_from    = IW'(MAX_TASKS - 1);
        case (state_reg)
            rrqd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.mode == rrqd_pkg::MODE_ADD)
                    begin
                        result_next = '0;
                        done_next   = 1'b1;
                        if (table_full)
                        begin
                            result_next.rejected = 1'b1;
                        end
                        else
                        begin
                            mem_we                         = 1'b1;
                            mem_waddr                      = fill_reg[IW-1:0];
                            mem_wdata.ident                = item.task_id;
                            mem_wdata.remaining            = item.burst;
                            live_next[fill_reg[IW-1:0]]    = 1'b1;
                            cursor_next                    = fill_reg[IW-1:0];
                            fill_next                      = fill_reg + FW'(1);
                        end
                    end
                    else if (live_reg[cursor_reg])
                    begin
                        slot_next = cursor_reg;
                    end
                    else
                    begin
                        // stale cursor: find the newest live task
                        scan_launch = 1'b1;
                    end
                end
            end
            rrqd_pkg::ST_FIND:
            begin
                if (scan_stat.hit)
                begin
                    slot_next = scan_idx;
                end
                else if (scan_stat.miss)
                begin
                    result_next           = '0;
                    result_next.empty_res = 1'b1;
                    done_next             = 1'b1;
                end
            end
            rrqd_pkg::ST_READ:
            begin
                mem_re = 1'b1;
            end
            rrqd_pkg::ST_CALC:
            begin
                mem_we              = 1'b1;
                mem_wdata.ident     = mem_rdata.ident;
                mem_wdata.remaining = rem_left;
                result_next           = '0;
                result_next.served_id = mem_rdata.ident;
                result_next.slice     = slice_val;
                if (rem_left == 16'd0)
                begin
                    result_next.finished = 1'b1;
                    live_next[slot_reg]  = 1'b0;
                end
                // next older live task, wrapping to the newest
                scan_launch = 1'b1;
                scan_from   = (slot_reg == '0) ? IW'(MAX_TASKS - 1) : slot_reg - IW'(1);
            end
            rrqd_pkg::ST_NEXT:
            begin
                if (scan_stat.hit)
                begin
                    cursor_next = scan_idx;
                    done_next   = 1'b1;
                end
                else if (scan_stat.miss)
                begin
                    fill_next   = '0;
                    cursor_next = '0;
                    done_next   = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rrqd_pkg::ST_IDLE;
            quantum_reg <= rrqd_pkg::QUANTUM_RESET;
            live_reg    <= '0;
            fill_reg    <= '0;
            cursor_reg  <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            quantum_reg <= quantum_next;
            live_reg    <= live_next;
            fill_reg    <= fill_next;
            cursor_reg  <= cursor_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

// ===== design/rrqd_checker.sv =====
// Port-level checker for the dispatcher, bound to the top level.
`default_nettype none

module rrqd_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            start,
    input wire logic            busy,
    input wire rrqd_pkg::item_t item,
    input wire logic            done,
    input wire rrqd_pkg::res_t  result
);

    // an add always answers in the next cycle
    a_add_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.mode == rrqd_pkg::MODE_ADD |=> done)
        else $error("add beat did not answer in the next cycle");

    // busy only rises on a taken dispatch
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a taken beat");

    // no result beat without a taken item or work in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy) || $past(busy))
        else $error("result beat without a taken item");

    // empty and rejected results carry nothing else
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.empty_res || result.rejected) |->
            result.served_id == 8'd0 && result.slice == 16'd0 && !result.finished &&
            !(result.empty_res && result.rejected))
        else $error("empty or rejected result carries task fields");

endmodule

bind round_robin_quantum_dispatcher_unit rrqd_checker u_rrqd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

`default_nettype wire

// ===== sim/rrqd_checker.sv =====
// Checker for the round-robin quantum dispatcher: tracks task table state and compares result beats.
module rrqd_scoreboard #(
    parameter int NSLOTS = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            busy,
    input  wire rrqd_pkg::item_t item,
    input  wire logic            done,
    input  wire rrqd_pkg::res_t  result,
    input  wire logic            cfg_valid,
    input  wire logic            cfg_ready,
    input  wire logic [15:0]     cfg_data,
    output int                   errors,
    output int                   outstanding
);

    logic [15:0]      quantum;
    logic [15:0]      time_left [NSLOTS];
    logic [7:0]       owner     [NSLOTS];
    bit               occupied  [NSLOTS];
    int               fill;
    int               cursor;
    rrqd_pkg::res_t   expected_results [$];
    int               mismatches = 0;
    int               queued = 0;

    assign errors      = mismatches;
    assign outstanding = queued;

    function automatic int older_task(input int from);
        for (int i = from - 1; i >= 0; i--)
            if (occupied[i])
                return i;
        return -1;
    endfunction

    // Apply one item to the table and return the result beat it should produce.
    function automatic rrqd_pkg::res_t dispatch_outcome(input rrqd_pkg::item_t it);
        rrqd_pkg::res_t r;
        int             slot;
        int             nxt;
        logic [15:0]    grant;
        r = '0;
        if (it.mode == rrqd_pkg::MODE_ADD)
        begin
            if (fill >= NSLOTS)
                r.rejected = 1'b1;
            else
            begin
                owner[fill]     = it.task_id;
                time_left[fill] = it.burst;
                occupied[fill]  = 1'b1;
                cursor          = fill;
                fill++;
            end
            return r;
        end
        // Stale cursor falls back to the newest live task.
        slot = (cursor < NSLOTS && occupied[cursor]) ? cursor : older_task(NSLOTS);
        if (slot < 0)
        begin
            r.empty_res = 1'b1;
            return r;
        end
        grant = (quantum < time_left[slot]) ? quantum : time_left[slot];
        time_left[slot] -= grant;
        r.served_id = owner[slot];
        r.slice     = grant;
        if (time_left[slot] == 16'd0)
        begin
            occupied[slot] = 1'b0;
            r.finished     = 1'b1;
        end
        nxt = older_task(slot);
        if (nxt < 0)
            nxt = older_task(NSLOTS);
        if (nxt < 0)
        begin
            fill   = 0;
            cursor = 0;
        end
        else
            cursor = nxt;
        return r;
    endfunction

    task automatic flag(input string what, input int want_v, input int got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t checker: %s expected %0d got %0d", $time, what, want_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rrqd_pkg::res_t want;
        if (!rst_n)
        begin
            quantum = rrqd_pkg::QUANTUM_RESET;
            for (int i = 0; i < NSLOTS; i++)
                occupied[i] = 1'b0;
            fill   = 0;
            cursor = 0;
            expected_results.delete();
            queued <= 0;
        end
        else
        begin
            // Retire the result beat first: it always belongs to an earlier item.
            if (done)
            begin
                if (expected_results.size() == 0)
                    flag("unexpected result beat, served_id", -1, int'(result.served_id));
                else
                begin
                    want = expected_results.pop_front();
                    if (result.served_id !== want.served_id)
                        flag("served_id", int'(want.served_id), int'(result.served_id));
                    if (result.slice !== want.slice)
                        flag("slice", int'(want.slice), int'(result.slice));
                    if (result.finished !== want.finished)
                        flag("finished", int'(want.finished), int'(result.finished));
                    if (result.empty_res !== want.empty_res)
                        flag("empty_res", int'(want.empty_res), int'(result.empty_res));
                    if (result.rejected !== want.rejected)
                        flag("rejected", int'(want.rejected), int'(result.rejected));
                end
            end
            if (cfg_valid && cfg_ready)
                quantum = cfg_data;
            if (start && !busy)
                expected_results.push_back(dispatch_outcome(item));
            queued <= expected_results.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the round-robin quantum dispatcher: stimulus, watchdog and verdict.
module tb_top;

    localparam int NSLOTS     = 32;
    localparam int WATCHDOG   = 5000;
    localparam int TAIL       = 2 * NSLOTS + 8;
    localparam int PHASE_LEN  = 155;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            start     = 1'b0;
    rrqd_pkg::item_t item      = '0;
    logic            cfg_valid = 1'b0;
    logic [15:0]     cfg_data  = '0;
    logic            busy;
    logic            done;
    logic            cfg_ready;
    rrqd_pkg::res_t  result;
    int              errors;
    int              outstanding;
    int              quiet     = 0;
    int              idle_pct  = 0;
    int              add_pct   = 50;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    round_robin_quantum_dispatcher_unit #(
        .MAX_TASKS(NSLOTS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    rrqd_scoreboard #(
        .NSLOTS(NSLOTS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .outstanding(outstanding)
    );

    // Count cycles with no beat on any channel.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= WATCHDOG)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic idle_gap();
        int n;
        n = 0;
        while ($urandom_range(99) < idle_pct)
            n++;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic issue(input rrqd_pkg::item_t it);
        idle_gap();
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic add_task(input logic [7:0] id, input logic [15:0] burst);
        rrqd_pkg::item_t it;
        it.mode    = rrqd_pkg::MODE_ADD;
        it.task_id = id;
        it.burst   = burst;
        issue(it);
    endtask

    // Id and burst are don't-care on a dispatch; randomize them anyway.
    task automatic dispatch_next();
        rrqd_pkg::item_t it;
        it.mode    = rrqd_pkg::MODE_DISPATCH;
        it.task_id = 8'($urandom);
        it.burst   = 16'($urandom);
        issue(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0 || busy);
    endtask

    task automatic set_quantum(input logic [15:0] q);
        drain();
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= q;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly short bursts so tasks finish and the table cycles through empty and full.
    function automatic logic [15:0] pick_burst();
        case ($urandom_range(19))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic run_phase(input logic [15:0] q, input int pct);
        set_quantum(q);
        idle_pct = pct;
        for (int k = 0; k < PHASE_LEN; k++)
        begin
            // Switch between filling, balanced and draining stretches.
            if (k % 40 == 0)
                case ($urandom_range(2))
                    0:       add_pct = 15;
                    1:       add_pct = 50;
                    default: add_pct = 85;
                endcase
            if ($urandom_range(99) < add_pct)
                add_task(8'($urandom), pick_burst());
            else
                dispatch_next();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dispatch_next();                 // empty table
        add_task(8'h00, 16'h0000);
        dispatch_next();                 // zero burst finishes at once, table empties
        add_task(8'hFF, 16'hFFFF);
        add_task(8'h5A, 16'd3);
        add_task(8'hA5, 16'd10);
        repeat (4) dispatch_next();      // newest first, then wrap to the newest live
        set_quantum(16'hFFFF);
        dispatch_next();                 // last task finishes, table empties
        dispatch_next();
        add_task(8'h81, 16'h7FFF);
        add_task(8'h7E, 16'h8000);
        repeat (2) dispatch_next();

        run_phase(16'd1, 74);
        run_phase(16'hFFFF, 37);
        run_phase(16'd0, 0);
        run_phase(16'hFFFF, 74);
        run_phase(16'($urandom_range(2, 40)), 37);
        run_phase(16'd10, 0);

        drain();
        repeat (TAIL) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rrqd_pkg.sv
design/rrqd_table.sv
design/rrqd_scan.sv
design/round_robin_quantum_dispatcher_unit.sv
design/rrqd_checker.sv
sim/rrqd_checker.sv
sim/tb_top.sv
